[src/bbc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

  localparam int unsigned DEF_STACK_DEPTH = 128;

  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_CURLY  = 2'd1,
    KIND_SQUARE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNMATCHED = 3'd1,
    ST_MISMATCH  = 3'd2,
    ST_UNCLOSED  = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LCURLY  = 8'h7b;
  localparam logic [7:0] CH_RCURLY  = 8'h7d;
  localparam logic [7:0] CH_LSQUARE = 8'h5b;
  localparam logic [7:0] CH_RSQUARE = 8'h5d;

  typedef struct packed {
    logic  push;
    logic  pop;
    logic  clear;
    kind_t kind;
  } stack_op_t;

endpackage

`default_nettype wire

[src/bbc_stack.sv]
`timescale 1ns / 1ps
`default_nettype none

module bbc_stack #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::DEF_STACK_DEPTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire bbc_pkg::stack_op_t                 op,
  output logic [$clog2(STACK_DEPTH+1)-1:0]        count,
  output bbc_pkg::kind_t                          tos
);
  import bbc_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  kind_t          mem [STACK_DEPTH];
  logic [CW-1:0]  count_r, count_nxt;
  kind_t          tos_r, tos_nxt;
  kind_t          below_r;
  logic [CW-1:0]  count_m1, rd_sum;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic           wr_en;

  // top entry lives in tos_r, the memory holds the entries below it;
  // below_r always tracks the entry just under the top
  always_comb begin
    count_nxt = count_r;
    tos_nxt   = tos_r;
    wr_en     = 1'b0;
    count_m1  = count_r - CW'(1);
    wr_addr   = count_m1[AW-1:0];
    if (op.clear) begin
      count_nxt = '0;
    end else if (op.push) begin
      wr_en     = (count_r != '0);
      count_nxt = count_r + CW'(1);
      tos_nxt   = op.kind;
    end else if (op.pop) begin
      count_nxt = count_m1;
      tos_nxt   = below_r;
    end
    rd_sum  = count_nxt - CW'(2);
    rd_addr = rd_sum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= tos_r;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      below_r <= tos_r;
    end else begin
      below_r <= mem[rd_addr];
    end
    tos_r <= tos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;
  assign tos   = tos_r;

endmodule

`default_nettype wire

[src/bracket_balance_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  tdata                             tlast  tuser
// in_      in   [7:0] symbol                      last   -
// out_     out  [0] valid_res, [3:1] status       -      -
//
// one item per cycle while in_tready is high; each item touches only the stack top,
// held in a register above a registered-read memory that forwards the entry below.
// a result is registered and leaves in the cycle after an expression's final item.
// synchronous active-low reset clears stack count, error and output valid.
// the output register stalls input only while a result waits and out_tready is low.

module bracket_balance_checker #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::DEF_STACK_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] symbol
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [0] valid_res, [3:1] status, [7:4] zero
);
  import bbc_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  stack_op_t      op;
  logic [CW-1:0]  count;
  kind_t          tos;

  status_t        err_r, err_nxt, res_status;
  logic           out_valid_r, out_valid_nxt;
  status_t        out_status_r, out_status_nxt;
  kind_t          open_kind, close_kind;
  logic           accept, take, full, empty, count_after_nz;

  bbc_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .count (count),
    .tos   (tos)
  );

  always_comb begin
    unique case (in_tdata)
      CH_LPAREN:  open_kind = KIND_ROUND;
      CH_LCURLY:  open_kind = KIND_CURLY;
      CH_LSQUARE: open_kind = KIND_SQUARE;
      default:    open_kind = KIND_NONE;
    endcase
    unique case (in_tdata)
      CH_RPAREN:  close_kind = KIND_ROUND;
      CH_RCURLY:  close_kind = KIND_CURLY;
      CH_RSQUARE: close_kind = KIND_SQUARE;
      default:    close_kind = KIND_NONE;
    endcase
  end

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign take      = accept && (err_r == ST_OK);
  assign full      = (count >= CW'(STACK_DEPTH));
  assign empty     = (count == '0);

  always_comb begin
    op.push        = 1'b0;
    op.pop         = 1'b0;
    op.clear       = accept && in_tlast;
    op.kind        = open_kind;
    err_nxt        = err_r;
    count_after_nz = !empty;
    if (take && (open_kind != KIND_NONE)) begin
      if (full) begin
        err_nxt = ST_OVERFLOW;
      end else begin
        op.push        = 1'b1;
        count_after_nz = 1'b1;
      end
    end else if (take && (close_kind != KIND_NONE)) begin
      if (empty) begin
        err_nxt = ST_UNMATCHED;
      end else begin
        op.pop         = 1'b1;
        count_after_nz = (count != CW'(1));
        if (tos != close_kind) begin
          err_nxt = ST_MISMATCH;
        end
      end
    end

    res_status = err_nxt;
    if ((err_nxt == ST_OK) && count_after_nz) begin
      res_status = ST_UNCLOSED;
    end

    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    if (accept && in_tlast) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status;
      err_nxt        = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_status_r, (out_status_r == ST_OK)};

endmodule

`default_nettype wire
